// ===== hdl/kcat_pkg.sv =====
// Package for the keypad countdown alarm timer: key codes, keypad decode,
// item and result types. No dependencies.
package kcat_pkg;

  typedef logic [3:0] key_t;

  localparam key_t KEY_START  = 4'd10;
  localparam key_t KEY_STOP   = 4'd11;
  localparam key_t KEY_SET    = 4'd12;
  localparam key_t KEY_NONE   = 4'd15;
  localparam key_t MAX_DIGIT  = 4'd9;
  localparam logic [3:0] MAX_TENS = 4'd5;
  localparam logic [1:0] MAX_COUNT = 2'd3;

  localparam int SECS_PER_MIN = 60;
  localparam int SECS_PER_TEN = 10;
  localparam int SECS_W       = 10;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic       action;  // 0 tick, 1 key press
    logic [1:0] key_row;
    logic [1:0] key_col;
  } item_t;

  typedef struct packed {
    logic       entry_mode;
    logic       alarm;
    logic       running;
    logic [3:0] ones_digit;
    logic [2:0] tens_digit;
    logic [3:0] minutes_digit;
  } res_t;

  // Layout: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
  function automatic key_t decode_key(logic [1:0] row, logic [1:0] col);
    key_t k;
    k = KEY_NONE;
    unique case ({row, col})
      4'h0: k = 4'd1;
      4'h1: k = 4'd2;
      4'h2: k = 4'd3;
      4'h3: k = KEY_START;
      4'h4: k = 4'd4;
      4'h5: k = 4'd5;
      4'h6: k = 4'd6;
      4'h7: k = KEY_STOP;
      4'h8: k = 4'd7;
      4'h9: k = 4'd8;
      4'hA: k = 4'd9;
      4'hD: k = 4'd0;
      4'hF: k = KEY_SET;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/keypad_countdown_alarm_timer_top.sv =====
// Top level of the keypad countdown alarm timer: input register, timer core,
// result register. Depends on kcat_pkg and kcat_core.
//
// channel | dir | handshake                     | payload
// s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: key_row, key_col; tuser: action
// m_axis  | out | m_axis_tvalid / m_axis_tready | tdata: display digits and flags
//
// One request per cycle sustained while m_axis_tready is high.
// The state update for a request is one combinational pass in kcat_core between
// the input register and the result register.
// Reset clears all timer state to zero at once; no sweep.
// A stalled result holds the result register; one more request waits in the input register.
module keypad_countdown_alarm_timer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [kcat_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // key_row[1:0], key_col[3:2]
  input  logic [0:0]                         s_axis_tuser,  // action[0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [kcat_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // minutes_digit[3:0],
                                                            // tens_digit[6:4], ones_digit[10:7],
                                                            // running[11], alarm[12], entry_mode[13]
);

  logic            in_vld_q;
  kcat_pkg::item_t in_q;
  logic            out_vld_q;
  kcat_pkg::res_t  out_q;
  kcat_pkg::res_t  res;
  logic            adv;
  logic            s_acc;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q.action  <= s_axis_tuser[0];
      in_q.key_row <= s_axis_tdata[1:0];
      in_q.key_col <= s_axis_tdata[3:2];
    end
  end

  kcat_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q};

`ifndef SYNTHESIS
  a_alarm_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!out_q.alarm || out_q.running))
    else $error("alarm without running");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q)
    else $error("pending request lost");
  a_result_after_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("result not presented");
`endif

endmodule

// ===== hdl/kcat_core.sv =====
// Timer state and its single-pass update for one request.
// Depends on kcat_pkg.
module kcat_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  kcat_pkg::item_t item_i,
  output kcat_pkg::res_t  res_o
);

  logic [2:0][3:0] ent_q, ent_d;    // [0] minutes, [1] tens, [2] ones
  logic [2:0][3:0] disp_q, disp_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [kcat_pkg::SECS_W-1:0] rem_q, rem_d;
  logic            run_q, run_d;
  logic            pause_q, pause_d;
  logic            acc_q, acc_d;
  kcat_pkg::key_t  key;
  logic [3:0]      tens_clip;
  logic [kcat_pkg::SECS_W-1:0] load_secs;

  assign key       = kcat_pkg::decode_key(item_i.key_row, item_i.key_col);
  assign tens_clip = (ent_q[2] > kcat_pkg::MAX_TENS) ? kcat_pkg::MAX_TENS : ent_q[2];
  assign load_secs = kcat_pkg::SECS_W'(ent_q[0] * kcat_pkg::SECS_W'(kcat_pkg::SECS_PER_MIN))
                   + kcat_pkg::SECS_W'(ent_q[1] * kcat_pkg::SECS_W'(kcat_pkg::SECS_PER_TEN))
                   + kcat_pkg::SECS_W'(ent_q[2]);

  always_comb begin
    ent_d   = ent_q;
    disp_d  = disp_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    run_d   = run_q;
    pause_d = pause_q;
    acc_d   = acc_q;
    if (!item_i.action) begin
      if (run_q && rem_q != '0) begin
        rem_d = rem_q - 1'b1;
        if (disp_q[2] != 4'd0) begin
          disp_d[2] = disp_q[2] - 1'b1;
        end else if (disp_q[1] != 4'd0) begin
          disp_d[2] = kcat_pkg::MAX_DIGIT;
          disp_d[1] = disp_q[1] - 1'b1;
        end else if (disp_q[0] != 4'd0) begin
          disp_d[2] = kcat_pkg::MAX_DIGIT;
          disp_d[1] = kcat_pkg::MAX_TENS;
          disp_d[0] = disp_q[0] - 1'b1;
        end
      end
    end else if (key <= kcat_pkg::MAX_DIGIT) begin
      if (acc_q && cnt_q != kcat_pkg::MAX_COUNT) begin
        ent_d  = {key, tens_clip, ent_q[1]};
        disp_d = {key, tens_clip, ent_q[1]};
        cnt_d  = cnt_q + 1'b1;
      end
    end else begin
      case (key)
        kcat_pkg::KEY_START: begin
          acc_d = 1'b0;
          run_d = 1'b1;
          if (!pause_q) begin
            rem_d  = load_secs;
            disp_d = ent_q;
          end
          pause_d = 1'b0;
        end
        kcat_pkg::KEY_STOP: begin
          run_d   = 1'b0;
          pause_d = 1'b1;
        end
        kcat_pkg::KEY_SET: begin
          ent_d   = '0;
          disp_d  = '0;
          cnt_d   = '0;
          acc_d   = 1'b1;
          pause_d = 1'b0;
          run_d   = 1'b0;
        end
        default: ;
      endcase
    end
    // alarm: count at zero clears the entry, the display and the digit count
    if (run_d && rem_d == '0) begin
      ent_d  = '0;
      disp_d = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q   <= '0;
      disp_q  <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      run_q   <= 1'b0;
      pause_q <= 1'b0;
      acc_q   <= 1'b0;
    end else if (en_i) begin
      ent_q   <= ent_d;
      disp_q  <= disp_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      run_q   <= run_d;
      pause_q <= pause_d;
      acc_q   <= acc_d;
    end
  end

  assign res_o.minutes_digit = disp_d[0];
  assign res_o.tens_digit    = disp_d[1][2:0];
  assign res_o.ones_digit    = disp_d[2];
  assign res_o.running       = run_d;
  assign res_o.alarm         = run_d && (rem_d == '0);
  assign res_o.entry_mode    = acc_d;

`ifndef SYNTHESIS
  a_run_excl_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_q && acc_q)) else $error("running while in digit entry");
  a_tens_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (disp_q[1] <= kcat_pkg::MAX_TENS) && (ent_q[1] <= kcat_pkg::MAX_TENS))
    else $error("tens digit above five");
  a_alarm_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && rem_q == '0) |-> (disp_q == '0 && cnt_q == '0))
    else $error("display not blank at alarm");
`endif

endmodule

// ===== tb/kcat_display_checker.sv =====
// Checker for the keypad countdown alarm timer: follows both stream channels,
// predicts each displayed result and compares it. Depends on kcat_pkg.
`timescale 1ns / 100ps

module kcat_display_checker
  import kcat_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,   // key_row[1:0], key_col[3:2]
  input  logic [0:0]             s_tuser_i,   // action[0]
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,   // minutes[3:0], tens[6:4], ones[10:7],
                                              // running[11], alarm[12], entry_mode[13]
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     checked_o,
  output int                     alarms_o
);

  // keypad layout indexed by {row, col}: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
  key_t keymap [16];
  initial begin
    keymap = '{4'd1, 4'd2, 4'd3, KEY_START,
               4'd4, 4'd5, 4'd6, KEY_STOP,
               4'd7, 4'd8, 4'd9, KEY_NONE,
               KEY_NONE, 4'd0, KEY_NONE, KEY_SET};
  end

  // predicted timer state
  logic [3:0]        ent [3];   // entered minutes, tens, ones
  logic [1:0]        ent_n;
  logic [3:0]        disp [3];  // displayed minutes, tens, ones
  logic [SECS_W-1:0] secs;
  logic              run, paused, entry;

  res_t display_q [$];

  task automatic clear_digits();
    ent   = '{default: 4'd0};
    disp  = '{default: 4'd0};
    ent_n = 2'd0;
  endtask

  task automatic predict_display(input item_t req, output res_t r);
    key_t       k;
    logic [3:0] t;
    if (!req.action) begin
      if (run && secs != 0) begin
        secs = secs - 1'b1;
        if (disp[2] != 0) begin
          disp[2] = disp[2] - 1'b1;
        end else if (disp[1] != 0) begin
          disp[2] = MAX_DIGIT;
          disp[1] = disp[1] - 1'b1;
        end else if (disp[0] != 0) begin
          disp[2] = MAX_DIGIT;
          disp[1] = MAX_TENS;
          disp[0] = disp[0] - 1'b1;
        end
      end
    end else begin
      k = keymap[{req.key_row, req.key_col}];
      if (k <= MAX_DIGIT) begin
        if (entry && ent_n < MAX_COUNT) begin
          // digit moving into the tens place is clamped to 5
          t      = (ent[2] > MAX_TENS) ? MAX_TENS : ent[2];
          ent[0] = ent[1];
          ent[1] = t;
          ent[2] = k;
          disp   = ent;
          ent_n  = ent_n + 1'b1;
        end
      end else if (k == KEY_START) begin
        entry = 1'b0;
        run   = 1'b1;
        if (!paused) begin
          secs = SECS_W'(ent[0] * SECS_PER_MIN + ent[1] * SECS_PER_TEN + ent[2]);
          disp = ent;
        end
        paused = 1'b0;
      end else if (k == KEY_STOP) begin
        run    = 1'b0;
        paused = 1'b1;
      end else if (k == KEY_SET) begin
        clear_digits();
        entry  = 1'b1;
        paused = 1'b0;
        run    = 1'b0;
      end
    end
    if (run && secs == 0) clear_digits();
    r               = '0;
    r.minutes_digit = disp[0];
    r.tens_digit    = disp[1][2:0];
    r.ones_digit    = disp[2];
    r.running       = run;
    r.alarm         = run && secs == 0;
    r.entry_mode    = entry;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count_o = fail_count_o + 1;
      if (fail_count_o <= 10)
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : mon
    item_t req;
    res_t  want, got, pred;
    if (!rst_ni) begin
      clear_digits();
      secs   = '0;
      run    = 1'b0;
      paused = 1'b0;
      entry  = 1'b0;
      display_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      alarms_o     = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = res_t'(m_tdata_i[13:0]);
        if (display_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result 0x%04h", $realtime, m_tdata_i);
        end else begin
          want = display_q.pop_front();
          check_field("minutes_digit", want.minutes_digit, got.minutes_digit);
          check_field("tens_digit", want.tens_digit, got.tens_digit);
          check_field("ones_digit", want.ones_digit, got.ones_digit);
          check_field("running", want.running, got.running);
          check_field("alarm", want.alarm, got.alarm);
          check_field("entry_mode", want.entry_mode, got.entry_mode);
          check_field("tdata padding", 0, m_tdata_i[OUT_TDATA_W-1:14]);
          checked_o = checked_o + 1;
          if (want.alarm) alarms_o = alarms_o + 1;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        req.action  = s_tuser_i[0];
        req.key_row = s_tdata_i[1:0];
        req.key_col = s_tdata_i[3:2];
        predict_display(req, pred);
        display_q.push_back(pred);
      end
      pending_o = display_q.size();
    end
  end

endmodule

// ===== tb/tb_keypad_countdown_alarm_timer_top.sv =====
// Testbench top for the keypad countdown alarm timer: clock, reset, key and
// tick requests, result back-pressure. Depends on kcat_pkg and kcat_display_checker.
`timescale 1ns / 100ps

module tb_keypad_countdown_alarm_timer_top;
  import kcat_pkg::*;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_KEY  = 1'b1;
  // {row, col} of the keys that do nothing
  localparam logic [3:0] POS_C    = 4'hB;
  localparam logic [3:0] POS_STAR = 4'hC;
  localparam logic [3:0] POS_HASH = 4'hE;

  localparam int N_ITEMS   = 1600;
  localparam int N_QUIET   = 200;
  localparam int MAX_CYCLES = 300000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic idle_en = 1'b1;
  int   stall_left = 0;
  int   n_sent = 0;
  int   cycles = 0;
  int   fail_count, pending, checked, alarms;

  always #5 clk_i = ~clk_i;

  keypad_countdown_alarm_timer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  kcat_display_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .alarms_o     (alarms)
  );

  // result back-pressure: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // called just after a rising edge; returns at the edge that takes the request
  task automatic send_item(input logic act, input logic [1:0] row, input logic [1:0] col);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, col, row};
    s_axis_tuser  <= act;
    // tready only moves at rising edges, so the falling edge sees it settled
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    n_sent++;
  endtask

  task automatic press_at(input logic [3:0] pos);
    send_item(ACT_KEY, pos[3:2], pos[1:0]);
  endtask

  task automatic press(input key_t k);
    logic [3:0] pos;
    if (k >= 4'd1 && k <= MAX_DIGIT)
      pos = {2'((k - 1) / 3), 2'((k - 1) % 3)};
    else if (k == 4'd0)      pos = 4'hD;
    else if (k == KEY_START) pos = 4'h3;
    else if (k == KEY_STOP)  pos = 4'h7;
    else if (k == KEY_SET)   pos = 4'hF;
    else                     pos = POS_C;
    press_at(pos);
  endtask

  task automatic tick();
    send_item(ACT_TICK, 2'($urandom), 2'($urandom));
  endtask

  task automatic noise();
    send_item(1'($urandom), 2'($urandom), 2'($urandom));
  endtask

  // set (usually), up to four digits, start, then ticks with pauses and stray keys
  task automatic timer_session();
    int n_dig, n_ticks;
    if ($urandom_range(0, 9) != 0) press(KEY_SET);
    n_dig = ($urandom_range(0, 3) != 0) ? 3 : $urandom_range(0, 4);
    for (int i = 0; i < n_dig; i++) begin
      if (i == 0 && n_dig >= 3 && $urandom_range(0, 9) < 7) press(4'd0);
      else press(key_t'($urandom_range(0, 9)));
      if ($urandom_range(0, 15) == 0) noise();
    end
    press(KEY_START);
    n_ticks = $urandom_range(0, 75);
    for (int i = 0; i < n_ticks; i++) begin
      case ($urandom_range(0, 39))
        0: begin
          press(KEY_STOP);
          repeat ($urandom_range(0, 2)) tick();
          if ($urandom_range(0, 3) != 0) press(KEY_START);
        end
        1: noise();
        2: press(KEY_START);
        default: tick();
      endcase
    end
    if ($urandom_range(0, 3) == 0) press(KEY_STOP);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    tick();                      // idle tick
    press(4'd5);                 // digit with entry closed
    press_at(POS_STAR);
    press_at(POS_HASH);
    press_at(POS_C);
    press(KEY_SET);
    press(4'd9);
    press(4'd7);                 // 9 moves to tens, clamped to 5
    press(4'd8);
    press(4'd0);                 // fourth digit
    press(KEY_START);
    tick();
    tick();
    press(KEY_STOP);
    tick();                      // paused
    press(KEY_START);            // resume
    tick();
    press(KEY_START);            // reload while running
    press(KEY_SET);              // set stops the count
    press(KEY_START);            // nothing entered: alarm at once
    tick();
    press(KEY_STOP);
    press(KEY_STOP);             // stop while stopped
    press(KEY_SET);
    press(4'd1);
    press(KEY_START);
    tick();                      // reaches zero

    // random part, quiet at the end
    while (n_sent < N_ITEMS) begin
      if (n_sent >= N_ITEMS - N_QUIET) idle_en <= 1'b0;
      if ($urandom_range(0, 9) == 0) noise();
      else timer_session();
    end
    s_axis_tvalid <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d key and tick requests; %0d results checked, %0d with alarm raised.",
             n_sent, checked, alarms);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== keypad_countdown_alarm_timer_top.f =====
hdl/kcat_pkg.sv
hdl/kcat_core.sv
hdl/keypad_countdown_alarm_timer_top.sv
tb/kcat_display_checker.sv
tb/tb_keypad_countdown_alarm_timer_top.sv
